// ----- src/tebsa_pkg.sv -----
// Shared types and constants of the two-ended buffer space allocator.
`timescale 1ns / 1ps
`default_nettype none

package tebsa_pkg;

	localparam int ALU_W  = 36;
	localparam int DP_W   = 34;
	localparam int USED_W = 33;

	typedef logic signed [ALU_W-1:0] alu_word_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic neg;
		logic zero;
	} alu_flags_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] size;
		logic        is_ethernet;
	} in_item_t;

	typedef struct packed {
		logic [31:0]       address;
		logic [2:0]        status;
		logic              out_of_space;
		logic [USED_W-1:0] bytes_used;
	} out_item_t;

	typedef struct packed {
		logic [31:0] tile;
		logic [31:0] address;
	} hdr_entry_t;

	// request operations
	localparam logic [1:0] OP_HDR_ALLOC  = 2'd0;
	localparam logic [1:0] OP_DATA_ALLOC = 2'd1;
	localparam logic [1:0] OP_BLOB_ALLOC = 2'd2;
	localparam logic [1:0] OP_HDR_LOOKUP = 2'd3;

	// result status
	localparam logic [2:0] ST_NEW     = 3'd0;
	localparam logic [2:0] ST_EXIST   = 3'd1;
	localparam logic [2:0] ST_NOTHING = 3'd2;
	localparam logic [2:0] ST_MISSING = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_SPACE_START   = 3'd0;
	localparam logic [2:0] REG_SPACE_END     = 3'd1;
	localparam logic [2:0] REG_HDR_FIXED     = 3'd2;
	localparam logic [2:0] REG_HDR_BYTES     = 3'd3;
	localparam logic [2:0] REG_MIN_WORKER    = 3'd4;
	localparam logic [2:0] REG_MIN_ETHERNET  = 3'd5;
	localparam logic [2:0] REG_DEF_WORKER    = 3'd6;
	localparam logic [2:0] REG_DEF_ETHERNET  = 3'd7;

	localparam logic [31:0] BLOB_TRIM_MASK = 32'hFFFF_F000;

	// lowest value of the down pointer: -2^33
	localparam logic signed [DP_W-1:0] DOWN_MIN = {2'b10, {(DP_W-2){1'b0}}};

endpackage

`default_nettype wire

// ----- src/tebsa_alu.sv -----
// Shared 36-bit add/subtract unit with sign and zero flags.
`timescale 1ns / 1ps
`default_nettype none

module tebsa_alu (
	input  tebsa_pkg::alu_op_t    op,
	input  tebsa_pkg::alu_word_t  a,
	input  tebsa_pkg::alu_word_t  b,
	output tebsa_pkg::alu_word_t  res,
	output tebsa_pkg::alu_flags_t flags
);

	assign res = (op == tebsa_pkg::ALU_SUB) ? (a - b) : (a + b);

	always_comb begin
		flags.neg  = res[tebsa_pkg::ALU_W-1];
		flags.zero = (res == '0);
	end

endmodule

`default_nettype wire

// ----- src/tebsa_hdr_mem.sv -----
// Header table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tebsa_hdr_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire  [AW-1:0]           waddr,
	input  tebsa_pkg::hdr_entry_t   wdata,
	input  wire                     re,
	input  wire  [AW-1:0]           raddr,
	output tebsa_pkg::hdr_entry_t   rdata
);

	tebsa_pkg::hdr_entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- src/two_ended_buffer_space_allocator_core.sv -----
// Top level: sequencer, state and config registers of the two-ended allocator.
//
//  channel   | ports                            | handshake
//  ----------+----------------------------------+-------------------------------
//  request   | start, req, busy                 | taken when start && !busy
//  result    | done, rsp                        | done strobes one cycle
//  config    | cfg_write, cfg_index, cfg_data   | written when cfg_write is high
//
// A data or blob item passes through TAKE or BLOB, then USED1, USED2, OOS1, OOS2
// and DONE before the next accept (a zero-size data item skips TAKE); a header
// item first runs a serial table scan (one entry a cycle through the single read
// port), and the shared 36-bit adder also forms the pointer update, bytes used
// and overlap test in turn.
// Reset clears the header table fill count and loads the down pointer with the
// region end less the reserved tail; the table memory itself is not cleared.
// The receiver cannot stall: the result is shown for the single done cycle.
`timescale 1ns / 1ps
`default_nettype none

module two_ended_buffer_space_allocator_core #(
	parameter int HEADER_ENTRIES      = 8,
	parameter int RESERVED_TAIL_BYTES = 0
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	input  tebsa_pkg::in_item_t    req,
	output logic                   busy,
	output logic                   done,
	output tebsa_pkg::out_item_t   rsp,
	input  wire                    cfg_write,
	input  wire  [2:0]             cfg_index,
	input  wire  [31:0]            cfg_data
);

	localparam int IDX_W = (HEADER_ENTRIES > 1) ? $clog2(HEADER_ENTRIES) : 1;
	localparam int CNT_W = $clog2(HEADER_ENTRIES + 1);
	localparam int DP_W  = tebsa_pkg::DP_W;
	localparam logic signed [DP_W-1:0] TOP_RESET =
		DP_W'(64'sd1048576 - 64'(RESERVED_TAIL_BYTES));
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HEADER_ENTRIES);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_SCAN  = 9'b000000010,
		S_TAKE  = 9'b000000100,
		S_BLOB  = 9'b000001000,
		S_USED1 = 9'b000010000,
		S_USED2 = 9'b000100000,
		S_OOS1  = 9'b001000000,
		S_OOS2  = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration
	logic [31:0]            start_q;
	logic signed [DP_W-1:0] top_q;
	logic [31:0]            hdr_fixed_q;
	logic [15:0]            hdr_bytes_q;
	logic [31:0]            min_w_q;
	logic [31:0]            min_e_q;
	logic [31:0]            def_w_q;
	logic [31:0]            def_e_q;

	// allocator state
	logic signed [DP_W-1:0] dp_q;
	logic [31:0]            blob_q;
	logic                   blob_taken_q;
	logic [CNT_W-1:0]       cnt_q;

	// current item
	logic [1:0]             op_q;
	logic [31:0]            size_q;
	logic                   eth_q;
	logic [31:0]            addr_q;
	logic [2:0]             status_q;
	tebsa_pkg::alu_word_t   acc_q;
	logic [tebsa_pkg::USED_W-1:0] used_q;
	logic                   oos_q;

	// table scan
	logic [CNT_W-1:0]       rd_idx_q;
	logic                   rd_vld_s1;

	tebsa_pkg::alu_op_t     alu_op;
	tebsa_pkg::alu_word_t   alu_a;
	tebsa_pkg::alu_word_t   alu_b;
	tebsa_pkg::alu_word_t   alu_res;
	tebsa_pkg::alu_flags_t  alu_flags;

	logic                   mem_we;
	logic                   mem_re;
	tebsa_pkg::hdr_entry_t  mem_wdata;
	tebsa_pkg::hdr_entry_t  rd_data;

	logic [31:0]            take_bytes;
	logic [31:0]            blob_want;
	logic [31:0]            blob_min;
	logic [31:0]            blob_extra;
	logic signed [DP_W-1:0] take_sat;
	logic [tebsa_pkg::USED_W-1:0] used_sat;
	logic                   scan_more;
	logic                   scan_hit;
	logic                   scan_miss;

	tebsa_alu u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.res   (alu_res),
		.flags (alu_flags)
	);

	tebsa_hdr_mem #(
		.DEPTH (HEADER_ENTRIES),
		.AW    (IDX_W)
	) u_hdr_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	always_comb begin
		take_bytes = (op_q == tebsa_pkg::OP_DATA_ALLOC) ? size_q : {16'b0, hdr_bytes_q};
		blob_min   = eth_q ? min_e_q : min_w_q;
		if (size_q != '0) begin
			blob_want = size_q;
		end else begin
			blob_want = eth_q ? def_e_q : def_w_q;
		end

		scan_more = (rd_idx_q < cnt_q);
		scan_hit  = (state_q == S_SCAN) && rd_vld_s1 && alu_flags.zero;
		scan_miss = !rd_vld_s1 && !scan_more;

		alu_op = tebsa_pkg::ALU_SUB;
		alu_a  = '0;
		alu_b  = '0;
		case (state_q)
			S_SCAN: begin
				alu_a = {4'b0, rd_data.tile};
				alu_b = {4'b0, size_q};
			end
			S_TAKE: begin
				alu_a = {{2{dp_q[DP_W-1]}}, dp_q};
				alu_b = {4'b0, take_bytes};
			end
			S_BLOB: begin
				alu_a = {4'b0, blob_want};
				alu_b = {4'b0, blob_min};
			end
			S_USED1: begin
				alu_a = {{2{top_q[DP_W-1]}}, top_q};
				alu_b = {{2{dp_q[DP_W-1]}}, dp_q};
			end
			S_USED2: begin
				alu_op = tebsa_pkg::ALU_ADD;
				alu_a  = acc_q;
				alu_b  = {4'b0, blob_q};
			end
			S_OOS1: begin
				alu_op = tebsa_pkg::ALU_ADD;
				alu_a  = {4'b0, start_q};
				alu_b  = {4'b0, blob_q};
			end
			S_OOS2: begin
				alu_a = {{2{dp_q[DP_W-1]}}, dp_q};
				alu_b = acc_q;
			end
			default: begin
				alu_op = tebsa_pkg::ALU_SUB;
			end
		endcase

		// below -2^33 the top three bits are not all ones
		if (alu_res[35] && !(alu_res[34] && alu_res[33])) begin
			take_sat = tebsa_pkg::DOWN_MIN;
		end else begin
			take_sat = alu_res[DP_W-1:0];
		end

		if (alu_res[35]) begin
			used_sat = '0;
		end else if (alu_res[34:33] != 2'b00) begin
			used_sat = '1;
		end else begin
			used_sat = alu_res[tebsa_pkg::USED_W-1:0];
		end

		if (!alu_flags.neg && !alu_flags.zero) begin
			blob_extra = alu_res[31:0] & tebsa_pkg::BLOB_TRIM_MASK;
		end else begin
			blob_extra = '0;
		end

		mem_re = (state_q == S_SCAN) && !scan_hit && scan_more;
		mem_wdata.tile    = size_q;
		mem_wdata.address = (state_q == S_TAKE) ? take_sat[31:0] : hdr_fixed_q;
		mem_we = 1'b0;
		if (state_q == S_TAKE && op_q == tebsa_pkg::OP_HDR_ALLOC) begin
			mem_we = 1'b1;
		end else if (state_q == S_SCAN && !scan_hit && scan_miss
			&& op_q == tebsa_pkg::OP_HDR_ALLOC && cnt_q == '0 && cnt_q != CNT_FULL) begin
			// very first header goes to the fixed address
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			start_q      <= '0;
			top_q        <= TOP_RESET;
			hdr_fixed_q  <= '0;
			hdr_bytes_q  <= 16'd32;
			min_w_q      <= 32'd65536;
			min_e_q      <= 32'd32768;
			def_w_q      <= 32'd65536;
			def_e_q      <= 32'd32768;
			dp_q         <= TOP_RESET;
			blob_q       <= '0;
			blob_taken_q <= 1'b0;
			cnt_q        <= '0;
			rd_idx_q     <= '0;
			rd_vld_s1    <= 1'b0;
			op_q         <= '0;
			size_q       <= '0;
			eth_q        <= 1'b0;
			addr_q       <= '0;
			status_q     <= tebsa_pkg::ST_NOTHING;
			acc_q        <= '0;
			used_q       <= '0;
			oos_q        <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					tebsa_pkg::REG_SPACE_START:  start_q     <= cfg_data;
					tebsa_pkg::REG_SPACE_END: begin
						top_q <= $signed({2'b00, cfg_data}) - DP_W'(RESERVED_TAIL_BYTES);
						dp_q  <= $signed({2'b00, cfg_data}) - DP_W'(RESERVED_TAIL_BYTES);
					end
					tebsa_pkg::REG_HDR_FIXED:    hdr_fixed_q <= cfg_data;
					tebsa_pkg::REG_HDR_BYTES:    hdr_bytes_q <= cfg_data[15:0];
					tebsa_pkg::REG_MIN_WORKER:   min_w_q     <= cfg_data;
					tebsa_pkg::REG_MIN_ETHERNET: min_e_q     <= cfg_data;
					tebsa_pkg::REG_DEF_WORKER:   def_w_q     <= cfg_data;
					tebsa_pkg::REG_DEF_ETHERNET: def_e_q     <= cfg_data;
					default: begin
					end
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q      <= req.operation;
						size_q    <= req.size;
						eth_q     <= req.is_ethernet;
						addr_q    <= '0;
						rd_idx_q  <= '0;
						rd_vld_s1 <= 1'b0;
						case (req.operation)
							tebsa_pkg::OP_HDR_ALLOC, tebsa_pkg::OP_HDR_LOOKUP: begin
								state_q <= S_SCAN;
							end
							tebsa_pkg::OP_DATA_ALLOC: begin
								if (req.size == '0) begin
									status_q <= tebsa_pkg::ST_NOTHING;
									state_q  <= S_USED1;
								end else begin
									state_q <= S_TAKE;
								end
							end
							tebsa_pkg::OP_BLOB_ALLOC: begin
								state_q <= S_BLOB;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						addr_q   <= rd_data.address;
						status_q <= tebsa_pkg::ST_EXIST;
						state_q  <= S_USED1;
					end else if (scan_miss) begin
						if (op_q == tebsa_pkg::OP_HDR_LOOKUP) begin
							status_q <= tebsa_pkg::ST_MISSING;
							state_q  <= S_USED1;
						end else if (cnt_q == CNT_FULL) begin
							status_q <= tebsa_pkg::ST_FULL;
							state_q  <= S_USED1;
						end else if (cnt_q == '0) begin
							addr_q   <= hdr_fixed_q;
							status_q <= tebsa_pkg::ST_NEW;
							cnt_q    <= cnt_q + 1'b1;
							state_q  <= S_USED1;
						end else begin
							state_q <= S_TAKE;
						end
					end else begin
						// one read issued per cycle, compared the cycle after
						rd_vld_s1 <= scan_more;
						if (scan_more) begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
				end
				S_TAKE: begin
					dp_q     <= take_sat;
					addr_q   <= take_sat[31:0];
					status_q <= tebsa_pkg::ST_NEW;
					if (op_q == tebsa_pkg::OP_HDR_ALLOC) begin
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= S_USED1;
				end
				S_BLOB: begin
					if (blob_extra != '0) begin
						addr_q <= start_q;
						if (blob_taken_q) begin
							status_q <= tebsa_pkg::ST_EXIST;
						end else begin
							blob_taken_q <= 1'b1;
							blob_q       <= blob_extra;
							status_q     <= tebsa_pkg::ST_NEW;
						end
					end else begin
						status_q <= tebsa_pkg::ST_NOTHING;
					end
					state_q <= S_USED1;
				end
				S_USED1: begin
					acc_q   <= alu_res;
					state_q <= S_USED2;
				end
				S_USED2: begin
					used_q  <= used_sat;
					state_q <= S_OOS1;
				end
				S_OOS1: begin
					acc_q   <= alu_res;
					state_q <= S_OOS2;
				end
				S_OOS2: begin
					oos_q   <= alu_flags.neg;
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	always_comb begin
		rsp.address      = addr_q;
		rsp.status       = status_q;
		rsp.out_of_space = oos_q;
		rsp.bytes_used   = used_q;
	end

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not make the block busy");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("header fill count above table depth");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (rd_idx_q <= cnt_q))
		else $error("header scan ran past the filled entries");

	a_empty_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == tebsa_pkg::ST_NOTHING
			|| rsp.status == tebsa_pkg::ST_MISSING
			|| rsp.status == tebsa_pkg::ST_FULL)) |-> (rsp.address == '0))
		else $error("nonzero address on a result that grants nothing");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the two-ended buffer space allocator core.
module tb;

	localparam int HDR_SLOTS = 8;
	localparam int TAIL_BYTES = 0;
	localparam int SETTLE_CYCLES = HDR_SLOTS + 12;
	localparam int STALL_LIMIT = 2000;
	localparam longint PTR_FLOOR = -(64'sd1 <<< 33);
	localparam longint USED_CEIL = (64'sd1 <<< 33) - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	tebsa_pkg::in_item_t req = '0;
	logic busy;
	logic done;
	tebsa_pkg::out_item_t rsp;
	logic cfg_write = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// allocator state as the testbench tracks it
	logic [31:0] reg_start = '0;
	logic [31:0] reg_end = 32'd1048576;
	logic [31:0] reg_hdr_fixed = '0;
	logic [15:0] reg_hdr_bytes = 16'd32;
	logic [31:0] reg_min_w = 32'd65536;
	logic [31:0] reg_min_e = 32'd32768;
	logic [31:0] reg_def_w = 32'd65536;
	logic [31:0] reg_def_e = 32'd32768;
	longint down_ptr = 1048576 - TAIL_BYTES;
	logic [31:0] blob_bytes = '0;
	bit blob_taken = 1'b0;
	bit hdr_valid [HDR_SLOTS];
	logic [31:0] hdr_tile [HDR_SLOTS];
	logic [31:0] hdr_addr [HDR_SLOTS];

	tebsa_pkg::out_item_t grants_due[$];
	int errors = 0;
	int idle_pct = 0;
	int stall_cycles = 0;

	two_ended_buffer_space_allocator_core #(
		.HEADER_ENTRIES(HDR_SLOTS),
		.RESERVED_TAIL_BYTES(TAIL_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] carve_down(input logic [31:0] bytes);
		down_ptr = down_ptr - longint'(bytes);
		if (down_ptr < PTR_FLOOR) down_ptr = PTR_FLOOR;
		return down_ptr[31:0];
	endfunction

	function automatic int find_tile(input logic [31:0] tile);
		for (int i = 0; i < HDR_SLOTS; i++)
			if (hdr_valid[i] && hdr_tile[i] == tile) return i;
		return -1;
	endfunction

	function automatic tebsa_pkg::out_item_t plan_request(input tebsa_pkg::in_item_t it);
		tebsa_pkg::out_item_t res;
		int slot;
		int free_slot;
		logic [31:0] floor_bytes;
		logic [31:0] want;
		logic [31:0] extra;
		longint used;
		res = '0;
		res.status = tebsa_pkg::ST_NOTHING;
		case (it.operation)
		tebsa_pkg::OP_HDR_ALLOC: begin
			slot = find_tile(it.size);
			if (slot >= 0) begin
				res.address = hdr_addr[slot];
				res.status = tebsa_pkg::ST_EXIST;
			end else begin
				free_slot = -1;
				for (int i = HDR_SLOTS - 1; i >= 0; i--)
					if (!hdr_valid[i]) free_slot = i;
				if (free_slot < 0) begin
					res.status = tebsa_pkg::ST_FULL;
				end else begin
					// table fills in order, so slot 0 free means the table is empty
					if (free_slot == 0) res.address = reg_hdr_fixed;
					else res.address = carve_down({16'b0, reg_hdr_bytes});
					hdr_valid[free_slot] = 1'b1;
					hdr_tile[free_slot] = it.size;
					hdr_addr[free_slot] = res.address;
					res.status = tebsa_pkg::ST_NEW;
				end
			end
		end
		tebsa_pkg::OP_DATA_ALLOC: begin
			if (it.size != 0) begin
				res.address = carve_down(it.size);
				res.status = tebsa_pkg::ST_NEW;
			end
		end
		tebsa_pkg::OP_BLOB_ALLOC: begin
			floor_bytes = it.is_ethernet ? reg_min_e : reg_min_w;
			want = (it.size != 0) ? it.size : (it.is_ethernet ? reg_def_e : reg_def_w);
			extra = (want > floor_bytes) ?
				((want - floor_bytes) & tebsa_pkg::BLOB_TRIM_MASK) : '0;
			if (extra != 0) begin
				res.address = reg_start;
				if (blob_taken) begin
					res.status = tebsa_pkg::ST_EXIST;
				end else begin
					blob_taken = 1'b1;
					blob_bytes = extra;
					res.status = tebsa_pkg::ST_NEW;
				end
			end
		end
		tebsa_pkg::OP_HDR_LOOKUP: begin
			slot = find_tile(it.size);
			if (slot >= 0) begin
				res.address = hdr_addr[slot];
				res.status = tebsa_pkg::ST_EXIST;
			end else begin
				res.status = tebsa_pkg::ST_MISSING;
			end
		end
		endcase
		used = (longint'(reg_end) - TAIL_BYTES) - down_ptr + longint'(blob_bytes);
		if (used < 0) used = 0;
		if (used > USED_CEIL) used = USED_CEIL;
		res.bytes_used = used[tebsa_pkg::USED_W-1:0];
		res.out_of_space = (down_ptr < longint'(reg_start) + longint'(blob_bytes));
		return res;
	endfunction

	task automatic send_request(input logic [1:0] op, input logic [31:0] size, input logic eth);
		tebsa_pkg::in_item_t it;
		it.operation = op;
		it.size = size;
		it.is_ethernet = eth;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= it;
		do @(posedge clk); while (busy);
		grants_due = {grants_due, plan_request(it)};
	endtask

	// wait until every result is in and the core has gone quiet
	task automatic drain;
		start <= 1'b0;
		while (grants_due.size() != 0 || busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
		tebsa_pkg::REG_SPACE_START: reg_start = value;
		tebsa_pkg::REG_SPACE_END: begin
			reg_end = value;
			down_ptr = longint'(value) - TAIL_BYTES;
		end
		tebsa_pkg::REG_HDR_FIXED: reg_hdr_fixed = value;
		tebsa_pkg::REG_HDR_BYTES: reg_hdr_bytes = value[15:0];
		tebsa_pkg::REG_MIN_WORKER: reg_min_w = value;
		tebsa_pkg::REG_MIN_ETHERNET: reg_min_e = value;
		tebsa_pkg::REG_DEF_WORKER: reg_def_w = value;
		tebsa_pkg::REG_DEF_ETHERNET: reg_def_e = value;
		default: begin
		end
		endcase
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [31:0] s, input logic [31:0] e,
			input logic [31:0] hf, input logic [31:0] hb, input logic [31:0] mw,
			input logic [31:0] me, input logic [31:0] dw, input logic [31:0] de);
		drain();
		write_reg(tebsa_pkg::REG_SPACE_START, s);
		write_reg(tebsa_pkg::REG_SPACE_END, e);
		write_reg(tebsa_pkg::REG_HDR_FIXED, hf);
		write_reg(tebsa_pkg::REG_HDR_BYTES, hb);
		write_reg(tebsa_pkg::REG_MIN_WORKER, mw);
		write_reg(tebsa_pkg::REG_MIN_ETHERNET, me);
		write_reg(tebsa_pkg::REG_DEF_WORKER, dw);
		write_reg(tebsa_pkg::REG_DEF_ETHERNET, de);
	endtask

	function automatic logic [31:0] pick_word;
		case ($urandom_range(5))
		0: return '0;
		1: return '1;
		2: return $urandom_range(65535);
		default: return $urandom;
		endcase
	endfunction

	task automatic send_random;
		logic [1:0] op;
		logic [31:0] size;
		logic eth;
		int pick;
		int n_valid;
		op = 2'($urandom_range(3));
		eth = 1'($urandom_range(1));
		pick = $urandom_range(9);
		case (op)
		tebsa_pkg::OP_HDR_ALLOC, tebsa_pkg::OP_HDR_LOOKUP: begin
			// mostly tiles already in the table, so repeats and lookups hit
			n_valid = 0;
			foreach (hdr_valid[i]) if (hdr_valid[i]) n_valid++;
			if (pick < 6 && n_valid > 0) size = hdr_tile[$urandom_range(n_valid - 1)];
			else if (pick < 8) size = $urandom_range(15);
			else size = $urandom;
		end
		tebsa_pkg::OP_DATA_ALLOC: begin
			if (pick < 1) size = '0;
			else if (pick < 6) size = $urandom_range(1, 4096);
			else if (pick < 8) size = $urandom_range(1, 1 << 20);
			else size = $urandom;
		end
		tebsa_pkg::OP_BLOB_ALLOC: begin
			if (pick < 3) size = '0;
			else if (pick < 6) size = (eth ? reg_min_e : reg_min_w) + $urandom_range(12000);
			else size = $urandom;
		end
		endcase
		send_request(op, size, eth);
	endtask

	task automatic test_directed_requests;
		send_request(tebsa_pkg::OP_HDR_LOOKUP, 32'd5, 1'b0);
		send_request(tebsa_pkg::OP_HDR_ALLOC, 32'd0, 1'b1);
		send_request(tebsa_pkg::OP_HDR_ALLOC, 32'd0, 1'b0);
		send_request(tebsa_pkg::OP_HDR_LOOKUP, 32'd0, 1'b1);
		send_request(tebsa_pkg::OP_HDR_ALLOC, 32'hFFFF_FFFF, 1'b0);
		send_request(tebsa_pkg::OP_DATA_ALLOC, 32'd0, 1'b0);
		send_request(tebsa_pkg::OP_DATA_ALLOC, 32'd1, 1'b1);
		send_request(tebsa_pkg::OP_BLOB_ALLOC, 32'd0, 1'b0);
		send_request(tebsa_pkg::OP_BLOB_ALLOC, 32'd0, 1'b1);
		// excess below 4 KiB trims to nothing
		send_request(tebsa_pkg::OP_BLOB_ALLOC, 32'd65536 + 32'd4095, 1'b0);
		send_request(tebsa_pkg::OP_BLOB_ALLOC, 32'd32768 + 32'd8192 + 32'd5, 1'b1);
		send_request(tebsa_pkg::OP_BLOB_ALLOC, 32'hFFFF_FFFF, 1'b0);
		for (int t = 1; t <= HDR_SLOTS - 2; t++)
			send_request(tebsa_pkg::OP_HDR_ALLOC, 32'(t), t[0]);
		send_request(tebsa_pkg::OP_HDR_ALLOC, 32'd7, 1'b0);
		send_request(tebsa_pkg::OP_HDR_LOOKUP, 32'hFFFF_FFFF, 1'b0);
		// run the pointer through the region start down to its floor
		repeat (3) send_request(tebsa_pkg::OP_DATA_ALLOC, 32'hFFFF_FFFF, 1'b1);
		send_request(tebsa_pkg::OP_DATA_ALLOC, 32'h8000_0000, 1'b0);
	endtask

	task automatic test_reprogrammed_region;
		drain();
		write_reg(tebsa_pkg::REG_SPACE_START, 32'h0000_1000);
		write_reg(tebsa_pkg::REG_SPACE_END, 32'h0020_0000);
		send_request(tebsa_pkg::OP_BLOB_ALLOC, 32'hFFFF_FFFF, 1'b0);
		send_request(tebsa_pkg::OP_DATA_ALLOC, 32'h0000_0100, 1'b0);
		send_request(tebsa_pkg::OP_HDR_LOOKUP, 32'd0, 1'b0);
		send_request(tebsa_pkg::OP_HDR_ALLOC, 32'h0000_0077, 1'b1);
		send_request(tebsa_pkg::OP_HDR_ALLOC, 32'd3, 1'b0);
	endtask

	task automatic test_config_extremes;
		idle_pct = 35;
		program_regs('1, '1, '1, '1, '1, '1, '1, '1);
		repeat (12) send_random();
		program_regs('0, '0, '0, '0, '0, '0, '0, '0);
		repeat (12) send_random();
		program_regs('0, '1, '1, '0, '1, '0, '0, '1);
		repeat (12) send_random();
	endtask

	task automatic test_random_traffic(input int pct, input int n_items);
		idle_pct = pct;
		for (int k = 0; k < n_items; k++) begin
			if (k % 80 == 0)
				program_regs($urandom_range(1) ? $urandom_range(65535) : pick_word(),
					$urandom_range(1) ? $urandom : pick_word(), pick_word(), pick_word(),
					pick_word(), pick_word(), pick_word(), pick_word());
			send_random();
		end
	endtask

	always @(posedge clk) begin
		tebsa_pkg::out_item_t want;
		if (arst_n && done) begin
			if (grants_due.size() == 0) begin
				errors++;
				$error("result with no request pending: address %h status %0d",
					rsp.address, rsp.status);
			end else begin
				want = grants_due.pop_front();
				if (rsp.address !== want.address) begin
					errors++;
					$error("address: expected %h, got %h", want.address, rsp.address);
				end
				if (rsp.status !== want.status) begin
					errors++;
					$error("status: expected %0d, got %0d", want.status, rsp.status);
				end
				if (rsp.out_of_space !== want.out_of_space) begin
					errors++;
					$error("out_of_space: expected %b, got %b",
						want.out_of_space, rsp.out_of_space);
				end
				if (rsp.bytes_used !== want.bytes_used) begin
					errors++;
					$error("bytes_used: expected %h, got %h", want.bytes_used, rsp.bytes_used);
				end
			end
		end
	end

	// watchdog: too long without any item moving either way
	always @(posedge clk) begin
		if ((start && !busy) || done) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[two_ended_buffer_space_allocator_core] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_requests();
		test_reprogrammed_region();
		test_config_extremes();
		test_random_traffic(35, 300);
		test_random_traffic(62, 300);
		test_random_traffic(0, 290);
		drain();
		if (errors == 0) begin
			$display("[two_ended_buffer_space_allocator_core] OK");
		end else begin
			$display("[two_ended_buffer_space_allocator_core] ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/tebsa_pkg.sv
src/tebsa_alu.sv
src/tebsa_hdr_mem.sv
src/two_ended_buffer_space_allocator_core.sv
tb/sv/tb.sv
